FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ORB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ORB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg
// Shared widths, operation codes and command type for the ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

    localparam int OP_W      = 3;
    localparam int REC_W     = 32;
    localparam int AMT_W     = 8;
    localparam int CNT_OUT_W = 6;
    localparam int LOST_W    = 16;

    localparam int DEPTH_DEF       = 32;
    localparam int RECORD_BITS_DEF = 32;

    // command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

    typedef enum logic [2:0] {
        K_PUSH,
        K_PEEK,
        K_COMMIT,
        K_CLEAR,
        K_STATUS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [REC_W-1:0]  record;
        logic [AMT_W-1:0]  amount;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/orb_front.sv
// ----------------------------------------------------------------------------
// orb_front
// Accepts input transactions, decodes the operation and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_front
    import orb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [REC_W-1:0]  record_in,
    input  wire logic [AMT_W-1:0]  amount,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_kind_t         kind;
    logic              push;

    // unknown codes behave as a status request
    always_comb
    begin
        unique case (operation)
            OP_PUSH:   kind = K_PUSH;
            OP_PEEK:   kind = K_PEEK;
            OP_COMMIT: kind = K_COMMIT;
            OP_CLEAR:  kind = K_CLEAR;
            OP_STATUS: kind = K_STATUS;
            default:   kind = K_STATUS;
        endcase
    end

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = push    ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].kind   <= kind;
            slot_reg[wr_ptr_reg].record <= record_in;
            slot_reg[wr_ptr_reg].amount <= amount;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/orb_back.sv
// ----------------------------------------------------------------------------
// orb_back
// Executes queued commands: ring store, counters, peek sequencer, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_back
    import orb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    input  wire cmd_t                  cmd,
    output logic                       cmd_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [REC_W-1:0]           record_out,
    output logic                       has_record,
    output logic                       last,
    output logic [CNT_OUT_W-1:0]       peek_taken,
    output logic [CNT_OUT_W-1:0]       pending,
    output logic [LOST_W-1:0]          lost_total
);

    localparam int PW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int SW     = CW + 1;
    localparam int KEEP_W = (RECORD_BITS < REC_W) ? RECORD_BITS : REC_W;
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL     = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PEEK = 2'b10
    } state_t;

    logic [KEEP_W-1:0] mem [DEPTH];

    state_t            state_reg, state_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [LOST_W-1:0] lost_reg, lost_next;
    logic [PW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     remain_reg, remain_next;
    logic [CW-1:0]     taken_reg, taken_next;
    logic              q_valid_reg;
    logic              q_last_reg;
    logic [KEEP_W-1:0] mem_q_reg;
    logic              out_valid_reg;

    logic              out_free;
    logic              start;
    logic              single;
    logic              q_adv;
    logic              rd_en;
    logic              amt_lt;
    logic [CW-1:0]     take;
    logic [SW-1:0]     wp_ext, held_ext, start_sum;
    logic [PW-1:0]     wp_inc, idx_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign start    = (state_reg == ST_IDLE) && cmd_valid && !q_valid_reg && out_free;
    assign q_adv    = q_valid_reg && out_free;
    assign rd_en    = (state_reg == ST_PEEK) && (!q_valid_reg || q_adv);

    assign amt_lt   = cmd.amount < AMT_W'(held_reg);
    assign take     = amt_lt ? CW'(cmd.amount) : held_reg;

    // oldest entry sits held entries behind the write position
    assign wp_ext    = SW'(wp_reg);
    assign held_ext  = SW'(held_reg);
    assign start_sum = (wp_ext >= held_ext) ? wp_ext - held_ext
                                            : wp_ext + SW'(DEPTH) - held_ext;

    assign wp_inc  = (wp_reg  == LAST_POS) ? '0 : wp_reg  + 1'b1;
    assign idx_inc = (idx_reg == LAST_POS) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        held_next   = held_reg;
        lost_next   = lost_reg;
        idx_next    = idx_reg;
        remain_next = remain_reg;
        taken_next  = taken_reg;
        cmd_pop     = 1'b0;
        single      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        K_PUSH:
                        begin
                            single  = 1'b1;
                            wp_next = wp_inc;
                            if (held_reg == FULL)
                                lost_next = lost_reg + 1'b1;
                            else
                                held_next = held_reg + 1'b1;
                        end
                        K_PEEK:
                        begin
                            if (take == '0)
                                single = 1'b1;
                            else
                            begin
                                state_next  = ST_PEEK;
                                idx_next    = start_sum[PW-1:0];
                                remain_next = take;
                                taken_next  = take;
                            end
                        end
                        K_COMMIT:
                        begin
                            single    = 1'b1;
                            held_next = amt_lt ? held_reg - CW'(cmd.amount) : '0;
                        end
                        K_CLEAR:
                        begin
                            single    = 1'b1;
                            wp_next   = '0;
                            held_next = '0;
                            lost_next = '0;
                        end
                        default:
                            single = 1'b1;
                    endcase
                end
            end
            ST_PEEK:
            begin
                if (rd_en)
                begin
                    idx_next    = idx_inc;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            held_reg      <= '0;
            lost_reg      <= '0;
            idx_reg       <= '0;
            remain_reg    <= '0;
            taken_reg     <= '0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            held_reg   <= held_next;
            lost_reg   <= lost_next;
            idx_reg    <= idx_next;
            remain_reg <= remain_next;
            taken_reg  <= taken_next;

            if (rd_en)
                q_valid_reg <= 1'b1;
            else if (q_adv)
                q_valid_reg <= 1'b0;

            if (q_adv || single)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (start && (cmd.kind == K_PUSH))
            mem[wp_reg] <= cmd.record[KEEP_W-1:0];
        if (rd_en)
        begin
            mem_q_reg  <= mem[idx_reg];
            q_last_reg <= (remain_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_adv)
        begin
            record_out <= REC_W'(mem_q_reg);
            has_record <= 1'b1;
            last       <= q_last_reg;
            peek_taken <= CNT_OUT_W'(taken_reg);
            pending    <= CNT_OUT_W'(held_reg);
            lost_total <= lost_reg;
        end
        else if (single)
        begin
            record_out <= '0;
            has_record <= 1'b0;
            last       <= 1'b1;
            peek_taken <= '0;
            pending    <= CNT_OUT_W'(held_next);
            lost_total <= lost_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/overwrite_ring_buffer_peek_commit.sv
// ----------------------------------------------------------------------------
// overwrite_ring_buffer_peek_commit
// Overwriting circular event store with peek and commit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   push, peek, commit, clear or status. Output channel (out_valid/out_ready)
//   carries result transactions; every command gives one, except a peek that
//   finds records, which gives one per record, oldest first, last set on the
//   final one.
//   A non-peek result is loaded into the result register when the back end
//   executes its command. A peek's records go through the store read
//   register into the result register, one record a cycle while the output
//   is drained. The back end takes one command a cycle while the output is
//   drained; a peek holds it to set up, read the store, then pass each record.
//   A two-entry command queue lets the input keep taking transactions while
//   the back end is busy or stalled.
//   Reset clears positions, counts and all valid flags; store contents are
//   left as they are and never read before being written, so no clearing
//   pass is run.
//   When the receiver holds out_ready low the result register holds, the
//   back end stops, and once the queue fills in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module overwrite_ring_buffer_peek_commit
    import orb_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [REC_W-1:0]      record_in,
    input  wire logic [AMT_W-1:0]      amount,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [REC_W-1:0]           record_out,
    output logic                       has_record,
    output logic                       last,
    output logic [CNT_OUT_W-1:0]       peek_taken,
    output logic [CNT_OUT_W-1:0]       pending,
    output logic [LOST_W-1:0]          lost_total
);

    // decoded commands waiting for the back end
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // front: accept, classify (unknown codes map to status), queue
    orb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .record_in (record_in),
        .amount    (amount),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: store, write position, held and lost counts, peek read-out
    orb_back
    #(
        .DEPTH       (DEPTH),
        .RECORD_BITS (RECORD_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .record_out (record_out),
        .has_record (has_record),
        .last       (last),
        .peek_taken (peek_taken),
        .pending    (pending),
        .lost_total (lost_total)
    );

endmodule

`default_nettype wire

FILE: rtl/orb_checker.sv
// ----------------------------------------------------------------------------
// orb_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module orb_checker
    import orb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [REC_W-1:0]      record_out,
    input  wire logic                  has_record,
    input  wire logic                  last,
    input  wire logic [CNT_OUT_W-1:0]  peek_taken,
    input  wire logic [CNT_OUT_W-1:0]  pending,
    input  wire logic [LOST_W-1:0]     lost_total
);

    // results without a record are single, empty transactions
    `ORB_ASSERT_IMP(a_plain_result, clk, rst_n, out_valid && !has_record, record_out == '0 && peek_taken == '0 && last)

    // a stalled result holds
    `ORB_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(record_out) && $stable(last) && $stable(pending))

    // within one peek, counts do not move between records
    `ORB_ASSERT_NXT(a_peek_steady, clk, rst_n, out_valid && out_ready && has_record && !last, $stable(pending) && $stable(lost_total) && $stable(peek_taken))

endmodule

bind overwrite_ring_buffer_peek_commit orb_checker u_orb_checker (.*);

`default_nettype wire
